### rtl/core/ttam_pkg.sv
// ----------------------------------------------------------------------------
// ttam_pkg
// Shared constants for the transpose address map: register indexes and the
// fixed widths of the configuration registers.
// ----------------------------------------------------------------------------
package ttam_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RANK       = 3'd0,
    REG_SRC_STRIDE = 3'd1,
    REG_DST_STRIDE = 3'd2,
    REG_AXIS_ORDER = 3'd3,
    REG_TOTAL_SIZE = 3'd4
  } cfg_reg_e;

  localparam int CFG_DATA_W      = 64;
  localparam int RANK_W          = 3;
  localparam int STRIDE_REG_W    = 64;
  localparam int AXIS_ORDER_W    = 8;
  localparam int TOTAL_W         = 32;
  localparam int AXIS_FIELD_BITS = 2;
  localparam int AXIS_SLOTS      = 4;

  localparam logic [RANK_W-1:0]       RANK_RST       = 3'd4;
  localparam logic [AXIS_ORDER_W-1:0] AXIS_ORDER_RST = 8'd228;

endpackage

### rtl/core/ttam_div_cell.sv
// ----------------------------------------------------------------------------
// ttam_div_cell
// One restoring-division step. A row of these cells splits the linear index
// into coordinates, one quotient bit per cell, one axis per INDEX_BITS cells.
// ----------------------------------------------------------------------------
module ttam_div_cell
  import ttam_pkg::*;
#(
  parameter int AXIS         = 0,
  parameter int BIT          = 0,
  parameter int MAX_RANK     = 4,
  parameter int STRIDE_BITS  = 16,
  parameter int INDEX_BITS   = 32,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  active_i,
  input  logic [STRIDE_BITS-1:0]                stride_i,
  input  logic                                  vld_i,
  input  logic                                  err_i,
  input  logic [ELEMENT_BITS-1:0]               val_i,
  input  logic [INDEX_BITS-1:0]                 a_i,
  input  logic [INDEX_BITS-1:0]                 q_i,
  input  logic [MAX_RANK-1:0][INDEX_BITS-1:0]   coord_i,
  output logic                                  vld_o,
  output logic                                  err_o,
  output logic [ELEMENT_BITS-1:0]               val_o,
  output logic [INDEX_BITS-1:0]                 a_o,
  output logic [INDEX_BITS-1:0]                 q_o,
  output logic [MAX_RANK-1:0][INDEX_BITS-1:0]   coord_o
);

  localparam int CW = ((INDEX_BITS > STRIDE_BITS) ? INDEX_BITS : STRIDE_BITS) + 1;

  logic                                vld_q;
  logic                                err_q;
  logic [ELEMENT_BITS-1:0]             val_q;
  logic [INDEX_BITS-1:0]               a_q, a_d;
  logic [INDEX_BITS-1:0]               q_q, q_d;
  logic [MAX_RANK-1:0][INDEX_BITS-1:0] coord_q, coord_d;
  logic [INDEX_BITS-1:0]               a_w, q_w;
  logic [INDEX_BITS:0]                 shifted;
  logic [CW-1:0]                       sh_ext, d_ext, diff;
  logic                                ge;

  // Shift in the next dividend bit, subtract the stride when it fits
  always_comb begin
    if (BIT == 0) begin
      a_w = '0;
      q_w = a_i;
    end else begin
      a_w = a_i;
      q_w = q_i;
    end
    shifted = {a_w, q_w[INDEX_BITS-1]};
    sh_ext  = CW'(shifted);
    d_ext   = CW'(stride_i);
    diff    = sh_ext - d_ext;
    ge      = (sh_ext >= d_ext);
    a_d     = ge ? diff[INDEX_BITS-1:0] : shifted[INDEX_BITS-1:0];
    q_d     = {q_w[INDEX_BITS-2:0], ge};
    coord_d = coord_i;
    if (BIT == INDEX_BITS - 1) begin
      coord_d[AXIS] = active_i ? q_d : '0;
    end
  end

  // Advance the item one cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_q   <= err_i;
      val_q   <= val_i;
      a_q     <= a_d;
      q_q     <= q_d;
      coord_q <= coord_d;
    end
  end

  assign vld_o   = vld_q;
  assign err_o   = err_q;
  assign val_o   = val_q;
  assign a_o     = a_q;
  assign q_o     = q_q;
  assign coord_o = coord_q;

endmodule

### rtl/core/ttam_addr_sum.sv
// ----------------------------------------------------------------------------
// ttam_addr_sum
// Permutes the coordinates, multiplies by the destination strides and sums
// the products into the destination address. Two register stages.
// ----------------------------------------------------------------------------
module ttam_addr_sum
  import ttam_pkg::*;
#(
  parameter int MAX_RANK     = 4,
  parameter int STRIDE_BITS  = 16,
  parameter int INDEX_BITS   = 32,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic [MAX_RANK-1:0]                   axis_act_i,
  input  logic [AXIS_ORDER_W-1:0]               axis_order_i,
  input  logic [MAX_RANK-1:0][STRIDE_BITS-1:0]  dstride_i,
  input  logic                                  vld_i,
  input  logic                                  err_i,
  input  logic [ELEMENT_BITS-1:0]               val_i,
  input  logic [MAX_RANK-1:0][INDEX_BITS-1:0]   coord_i,
  output logic                                  vld_o,
  output logic                                  err_o,
  output logic [ELEMENT_BITS-1:0]               val_o,
  output logic [INDEX_BITS-1:0]                 addr_o
);

  localparam int PW = INDEX_BITS + STRIDE_BITS;

  logic                                vld1_q, vld2_q;
  logic                                err1_q, err2_q;
  logic [ELEMENT_BITS-1:0]             val1_q, val2_q;
  logic [MAX_RANK-1:0][INDEX_BITS-1:0] prod_d, prod_q;
  logic [INDEX_BITS-1:0]               sum_d, addr_q;

  // Select the source coordinate of each destination axis and scale it
  always_comb begin
    for (int j = 0; j < MAX_RANK; j++) begin
      logic [AXIS_FIELD_BITS-1:0] src;
      logic [INDEX_BITS-1:0]      sel;
      logic                       ok;
      logic [PW-1:0]              p;
      src = '0;
      if (j < AXIS_SLOTS) begin
        src = axis_order_i[j*AXIS_FIELD_BITS +: AXIS_FIELD_BITS];
      end
      sel = '0;
      ok  = 1'b0;
      for (int k = 0; k < MAX_RANK; k++) begin
        if (int'(src) == k) begin
          sel = coord_i[k];
          ok  = axis_act_i[k];
        end
      end
      p = PW'(sel) * PW'(dstride_i[j]);
      prod_d[j] = (ok && axis_act_i[j]) ? p[INDEX_BITS-1:0] : '0;
    end
  end

  // Add the products, wrapping at the index width
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < MAX_RANK; j++) begin
      sum_d = sum_d + prod_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err1_q <= err_i;
      val1_q <= val_i;
      prod_q <= prod_d;
      err2_q <= err1_q;
      val2_q <= val1_q;
      addr_q <= err1_q ? '0 : sum_d;
    end
  end

  assign vld_o  = vld2_q;
  assign err_o  = err2_q;
  assign val_o  = val2_q;
  assign addr_o = addr_q;

endmodule

### rtl/core/tensor_transpose_address_map_top.sv
// ----------------------------------------------------------------------------
// tensor_transpose_address_map_top
// Transpose copy address generator: linear source index in, destination
// address and element value out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one source element per transfer: tdata holds the linear
//   index (low bits) and the element value. m_axis returns one transfer per
//   input: tdata holds the destination address and the value, tuser the
//   error flag (index at or past total size, or a zero stride in use).
//   Configuration writes (cfg_*) are taken every cycle; issue them only
//   while no element is in flight.
//   Throughput is one element per cycle while the skid stage is empty.
//   Each element passes one cell of the division row per quotient bit and
//   axis, then a multiply stage, a sum stage and the output register.
//   Reset clears all valid bits and loads the register defaults (rank 4,
//   identity axis order, zero strides and size).
//   When the receiver stalls, the output register holds and a skid stage
//   takes one more result; the whole row then stops and s_axis_tready drops
//   until the skid stage drains.
// ----------------------------------------------------------------------------
module tensor_transpose_address_map_top
  import ttam_pkg::*;
#(
  parameter int MAX_RANK     = 4,
  parameter int STRIDE_BITS  = 16,
  parameter int INDEX_BITS   = 32,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // linear_index, element_value
  input  logic [((INDEX_BITS+ELEMENT_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // write_address, moved_value
  output logic [((INDEX_BITS+ELEMENT_BITS+7)/8)*8-1:0] m_axis_tdata,
  // index_error
  output logic                  m_axis_tuser
);

  localparam int NCELL = MAX_RANK * INDEX_BITS;
  localparam int XW    = (INDEX_BITS > TOTAL_W) ? INDEX_BITS : TOTAL_W;

  logic [RANK_W-1:0]       rank_q;
  logic [STRIDE_REG_W-1:0] sstr_q, dstr_q;
  logic [AXIS_ORDER_W-1:0] order_q;
  logic [TOTAL_W-1:0]      total_q;

  // Take configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= RANK_RST;
      sstr_q  <= '0;
      dstr_q  <= '0;
      order_q <= AXIS_ORDER_RST;
      total_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RANK:       rank_q  <= cfg_data_i[RANK_W-1:0];
        REG_SRC_STRIDE: sstr_q  <= cfg_data_i;
        REG_DST_STRIDE: dstr_q  <= cfg_data_i;
        REG_AXIS_ORDER: order_q <= cfg_data_i[AXIS_ORDER_W-1:0];
        REG_TOTAL_SIZE: total_q <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack strides and mark axes in use
  logic [MAX_RANK-1:0][STRIDE_BITS-1:0] sstride, dstride;
  logic [MAX_RANK-1:0]                  axis_act;
  logic                                 stride_bad;

  always_comb begin
    stride_bad = 1'b0;
    for (int j = 0; j < MAX_RANK; j++) begin
      logic [STRIDE_REG_W-1:0] ss, ds;
      ss = '0;
      ds = '0;
      if (j * STRIDE_BITS < STRIDE_REG_W) begin
        ss = sstr_q >> (j * STRIDE_BITS);
        ds = dstr_q >> (j * STRIDE_BITS);
      end
      sstride[j]  = ss[STRIDE_BITS-1:0];
      dstride[j]  = ds[STRIDE_BITS-1:0];
      axis_act[j] = (j == 0) || (j < int'(rank_q));
      if (axis_act[j] && ((sstride[j] == '0) || (dstride[j] == '0))) begin
        stride_bad = 1'b1;
      end
    end
  end

  // Input side
  logic                    en;
  logic [INDEX_BITS-1:0]   in_idx;
  logic [ELEMENT_BITS-1:0] in_val;
  logic                    in_err;

  assign in_idx = s_axis_tdata[INDEX_BITS-1:0];
  assign in_val = s_axis_tdata[INDEX_BITS +: ELEMENT_BITS];
  assign in_err = (XW'(in_idx) >= XW'(total_q)) || stride_bad;
  assign s_axis_tready = en;

  // Division row
  logic [NCELL:0]                                vld_c, err_c;
  logic [NCELL:0][ELEMENT_BITS-1:0]              val_c;
  logic [NCELL:0][INDEX_BITS-1:0]                a_c, q_c;
  logic [NCELL:0][MAX_RANK-1:0][INDEX_BITS-1:0]  coord_c;

  assign vld_c[0]   = s_axis_tvalid;
  assign err_c[0]   = in_err;
  assign val_c[0]   = in_val;
  assign a_c[0]     = in_idx;
  assign q_c[0]     = '0;
  assign coord_c[0] = '0;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    ttam_div_cell #(
      .AXIS        (c / INDEX_BITS),
      .BIT         (c % INDEX_BITS),
      .MAX_RANK    (MAX_RANK),
      .STRIDE_BITS (STRIDE_BITS),
      .INDEX_BITS  (INDEX_BITS),
      .ELEMENT_BITS(ELEMENT_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .active_i(axis_act[c / INDEX_BITS]),
      .stride_i(sstride[c / INDEX_BITS]),
      .vld_i   (vld_c[c]),
      .err_i   (err_c[c]),
      .val_i   (val_c[c]),
      .a_i     (a_c[c]),
      .q_i     (q_c[c]),
      .coord_i (coord_c[c]),
      .vld_o   (vld_c[c+1]),
      .err_o   (err_c[c+1]),
      .val_o   (val_c[c+1]),
      .a_o     (a_c[c+1]),
      .q_o     (q_c[c+1]),
      .coord_o (coord_c[c+1])
    );
  end

  // Address forming
  logic                    p_vld, p_err;
  logic [ELEMENT_BITS-1:0] p_val;
  logic [INDEX_BITS-1:0]   p_addr;

  ttam_addr_sum #(
    .MAX_RANK    (MAX_RANK),
    .STRIDE_BITS (STRIDE_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_addr_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .axis_act_i  (axis_act),
    .axis_order_i(order_q),
    .dstride_i   (dstride),
    .vld_i       (vld_c[NCELL]),
    .err_i       (err_c[NCELL]),
    .val_i       (val_c[NCELL]),
    .coord_i     (coord_c[NCELL]),
    .vld_o       (p_vld),
    .err_o       (p_err),
    .val_o       (p_val),
    .addr_o      (p_addr)
  );

  // Output register with skid stage
  logic                    out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic                    out_err_q, out_err_d, skid_err_q, skid_err_d;
  logic [ELEMENT_BITS-1:0] out_val_q, out_val_d, skid_val_q, skid_val_d;
  logic [INDEX_BITS-1:0]   out_addr_q, out_addr_d, skid_addr_q, skid_addr_d;
  logic                    take, push;

  assign en   = ~skid_vld_q;
  assign take = out_vld_q & m_axis_tready;
  assign push = en & p_vld;

  always_comb begin
    out_vld_d   = out_vld_q & ~take;
    out_err_d   = out_err_q;
    out_val_d   = out_val_q;
    out_addr_d  = out_addr_q;
    skid_vld_d  = skid_vld_q;
    skid_err_d  = skid_err_q;
    skid_val_d  = skid_val_q;
    skid_addr_d = skid_addr_q;
    if (skid_vld_q && (take || !out_vld_q)) begin
      out_vld_d  = 1'b1;
      out_err_d  = skid_err_q;
      out_val_d  = skid_val_q;
      out_addr_d = skid_addr_q;
      skid_vld_d = 1'b0;
    end else if (push) begin
      if (take || !out_vld_q) begin
        out_vld_d  = 1'b1;
        out_err_d  = p_err;
        out_val_d  = p_val;
        out_addr_d = p_addr;
      end else begin
        skid_vld_d  = 1'b1;
        skid_err_d  = p_err;
        skid_val_d  = p_val;
        skid_addr_d = p_addr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_err_q   <= out_err_d;
    out_val_q   <= out_val_d;
    out_addr_q  <= out_addr_d;
    skid_err_q  <= skid_err_d;
    skid_val_q  <= skid_val_d;
    skid_addr_q <= skid_addr_d;
  end

  // Pack the result transfer
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[INDEX_BITS-1:0]            = out_addr_q;
    m_axis_tdata[INDEX_BITS +: ELEMENT_BITS] = out_val_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_err_q;

endmodule
